// File: design/lcar_pkg.sv
package lcar_pkg;

   // Width of the result value and of every internal offset or weight word.
   localparam int VALUE_W = 24;
   // Fraction bits of the scale register.
   localparam int FRAC_BITS = 8;
   // Dividend width: a value word with the fraction bits appended.
   localparam int NUM_W = VALUE_W + FRAC_BITS;
   localparam int STEP_W = $clog2(NUM_W);
   localparam logic [VALUE_W-1:0] SCALE_RESET = 24'd110080;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW,
      PH_XHIGH,
      PH_XLOW
   } phase_type;

   typedef struct packed {
      logic start;
      logic ack;
   } div_ctrl_type;

endpackage

// File: design/lcar_div.sv
module lcar_div (
   input  logic                            clock,
   input  logic                            reset,
   input  lcar_pkg::div_ctrl_type          ctrl,
   input  logic [lcar_pkg::NUM_W-1:0]      numer,
   input  logic [lcar_pkg::VALUE_W-1:0]    denom,
   output logic                            quo_valid,
   output logic [lcar_pkg::VALUE_W-1:0]    quo_sat
);
   import lcar_pkg::*;

   logic                run_ff, run_in;
   logic                valid_ff, valid_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [VALUE_W-1:0]  den_ff, den_in;
   logic [VALUE_W:0]    trial;
   logic [VALUE_W-1:0]  trial_sub;
   logic                fits;
   logic                last_step;

   // One restoring step per cycle: the dividend shifts out of the top of the
   // quotient register while quotient bits shift in at the bottom.
   always_comb begin
      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial[VALUE_W-1:0] - den_ff;
      fits      = (trial >= {1'b0, den_ff});
      last_step = run_ff && (step_ff == STEP_W'(NUM_W - 1));

      run_in   = run_ff;
      valid_in = valid_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;

      if (ctrl.start) begin
         run_in   = 1'b1;
         valid_in = 1'b0;
         step_in  = '0;
         rem_in   = '0;
         quo_in   = numer;
         den_in   = denom;
      end else if (run_ff) begin
         step_in = step_ff + 1'b1;
         rem_in  = fits ? trial_sub : trial[VALUE_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         if (last_step) begin
            run_in   = 1'b0;
            valid_in = 1'b1;
         end
      end else if (ctrl.ack) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         run_ff   <= run_in;
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // A zero divisor yields an all-ones quotient, so it saturates here as well.
   assign quo_valid = valid_ff;
   assign quo_sat   = (|quo_ff[NUM_W-1:VALUE_W]) ? '1 : quo_ff[VALUE_W-1:0];

endmodule

// File: design/load_cell_adc_reader_with_tare.sv
// Reader for a 24-bit bridge converter on channel A at gain 128, with tare.
// Each word on the req_ channel is one half-bit-period tick: a start request,
// the tare flag that goes with it, and the sampled level of the data pin.
// Each tick returns exactly one word on the rsp_ channel: the serial clock
// level to drive, busy and done flags, the tare flag and the value.
// A conversion waits for the data pin to go low, clocks in DATA_BITS bits
// MSB first plus one gain pulse, and finishes on its last low tick.
// Flow: a tick's response is registered and shows in the cycle after the
// tick is accepted, so ordinary ticks run at one per cycle while responses
// are taken. The finishing tick of a weight measurement goes through the
// bit-serial divider, one quotient bit per cycle; its response is written
// once the quotient is in, and no tick is taken meanwhile. The input is
// taken while a response waits, as long as the receiver takes it in the
// same cycle; when the receiver stalls, the response holds and the input
// stalls behind it. The scale register is written by csr_wr_en and
// csr_wr_data; the user must do so only while idle (not enforced by the block).
// Reset returns to idle with the serial clock high (converter powered
// down), the tare offset and last weight at zero and the scale at 110080.
module load_cell_adc_reader_with_tare #(
   parameter int DATA_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_start_req,
   input  logic                          req_tare,
   input  logic                          req_dout,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_sck,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic                          rsp_was_tare,
   output logic [lcar_pkg::VALUE_W-1:0]  rsp_value,
   input  logic                          csr_wr_en,
   input  logic [lcar_pkg::VALUE_W-1:0]  csr_wr_data
);
   import lcar_pkg::*;

   localparam int CNT_W = $clog2(DATA_BITS + 1);
   localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      cnt_next;
   logic [DATA_BITS-1:0]  shift_ff, shift_in;
   logic [VALUE_W-1:0]    tare_off_ff, tare_off_in;
   logic [VALUE_W-1:0]    weight_ff;
   logic                  tare_lat_ff, tare_lat_in;
   logic                  clk_lvl_ff, clk_lvl_in;
   logic [VALUE_W-1:0]    scale_ff;
   logic                  pend_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_sck_ff, rsp_busy_ff, rsp_done_ff, rsp_tare_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;

   logic                  req_fire;
   logic                  slot_free;
   logic                  div_take;
   logic [VALUE_W-1:0]    raw;
   logic [VALUE_W-1:0]    diff;
   logic                  tick_busy, tick_done, tick_tare;
   logic [VALUE_W-1:0]    tick_val;
   logic                  start_div;
   div_ctrl_type          div_ctrl;
   logic                  quo_valid;
   logic [VALUE_W-1:0]    quo_sat;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_ff && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign div_take  = pend_ff && quo_valid && slot_free;

   assign cnt_next = cnt_ff + 1'b1;
   assign raw      = VALUE_W'(shift_ff ^ TOP_BIT);
   assign diff     = raw - tare_off_ff;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:  if (req_start_req) phase_in = PH_WAIT;
         PH_WAIT:  if (!req_dout) phase_in = PH_HIGH;
         PH_HIGH:  phase_in = PH_LOW;
         PH_LOW:   phase_in = (cnt_next >= CNT_W'(DATA_BITS)) ? PH_XHIGH : PH_HIGH;
         PH_XHIGH: phase_in = PH_XLOW;
         PH_XLOW:  phase_in = PH_IDLE;
         default:  phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      cnt_in      = cnt_ff;
      shift_in    = shift_ff;
      tare_off_in = tare_off_ff;
      tare_lat_in = tare_lat_ff;
      clk_lvl_in  = clk_lvl_ff;
      tick_busy   = 1'b1;
      tick_done   = 1'b0;
      tick_tare   = 1'b0;
      tick_val    = '0;
      start_div   = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            tick_busy = req_start_req;
            if (req_start_req) begin
               clk_lvl_in  = 1'b0;
               tare_lat_in = req_tare;
            end
         end
         PH_WAIT: begin
            clk_lvl_in = 1'b0;
            if (!req_dout) begin
               cnt_in   = '0;
               shift_in = '0;
            end
         end
         PH_HIGH: begin
            clk_lvl_in = 1'b1;
            shift_in   = {shift_ff[DATA_BITS-2:0], 1'b0};
         end
         PH_LOW: begin
            clk_lvl_in = 1'b0;
            shift_in   = {shift_ff[DATA_BITS-1:1], req_dout};
            cnt_in     = cnt_next;
         end
         PH_XHIGH: begin
            clk_lvl_in = 1'b1;
         end
         PH_XLOW: begin
            clk_lvl_in = 1'b0;
            tick_busy  = 1'b0;
            tick_done  = 1'b1;
            if (tare_lat_ff) begin
               tare_off_in = raw;
               tick_tare   = 1'b1;
               tick_val    = raw;
            end else if (raw > tare_off_ff) begin
               start_div = 1'b1;
            end else begin
               tick_val = weight_ff;
            end
         end
         default: begin
            tick_busy = 1'b0;
         end
      endcase
   end

   assign div_ctrl.start = req_fire && start_div;
   assign div_ctrl.ack   = div_take;

   lcar_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .numer     ({diff, {FRAC_BITS{1'b0}}}),
      .denom     (scale_ff),
      .quo_valid (quo_valid),
      .quo_sat   (quo_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cnt_ff      <= '0;
         shift_ff    <= '0;
         tare_off_ff <= '0;
         weight_ff   <= '0;
         tare_lat_ff <= 1'b0;
         clk_lvl_ff  <= 1'b1;
         scale_ff    <= SCALE_RESET;
         pend_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff    <= phase_in;
            cnt_ff      <= cnt_in;
            shift_ff    <= shift_in;
            tare_off_ff <= tare_off_in;
            tare_lat_ff <= tare_lat_in;
            clk_lvl_ff  <= clk_lvl_in;
         end
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         if (req_fire && start_div) begin
            pend_ff <= 1'b1;
         end else if (div_take) begin
            pend_ff   <= 1'b0;
            weight_ff <= quo_sat;
         end
      end
   end

   // Each tick sets a response word; a divided weight's waits for the quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && !start_div) begin
         rsp_valid_ff <= 1'b1;
      end else if (div_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !start_div) begin
         rsp_sck_ff   <= clk_lvl_in;
         rsp_busy_ff  <= tick_busy;
         rsp_done_ff  <= tick_done;
         rsp_tare_ff  <= tick_tare;
         rsp_value_ff <= tick_val;
      end else if (div_take) begin
         rsp_sck_ff   <= 1'b0;
         rsp_busy_ff  <= 1'b0;
         rsp_done_ff  <= 1'b1;
         rsp_tare_ff  <= 1'b0;
         rsp_value_ff <= quo_sat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sck      = rsp_sck_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_was_tare = rsp_tare_ff;
   assign rsp_value    = rsp_value_ff;

endmodule

// File: design/lcar_checker.sv
module lcar_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_sck,
   input logic                          rsp_busy_res,
   input logic                          rsp_done_res,
   input logic                          rsp_was_tare,
   input logic [lcar_pkg::VALUE_W-1:0]  rsp_value
);
   import lcar_pkg::*;

   // A stalled response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response word changed while stalled");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_sck)
      else $error("finishing word shows busy or a high serial clock");

   a_idle_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_value == '0 && !rsp_was_tare)
      else $error("non-finishing word carries a value or tare flag");

   a_tare_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_tare |-> rsp_done_res)
      else $error("tare flag without done");

endmodule

bind load_cell_adc_reader_with_tare lcar_checker u_lcar_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_sck      (rsp_sck),
   .rsp_busy_res (rsp_busy_res),
   .rsp_done_res (rsp_done_res),
   .rsp_was_tare (rsp_was_tare),
   .rsp_value    (rsp_value)
);

// File: tb/sv/load_cell_adc_reader_with_tare_tb.sv
`timescale 1ns / 1ps

module load_cell_adc_reader_with_tare_tb;
   import lcar_pkg::*;

   localparam logic [VALUE_W-1:0] SIGN_FLIP = 24'h800000;
   localparam logic [VALUE_W-1:0] FULL_SCALE = 24'hFFFFFF;

   typedef struct {
      logic               sck;
      logic               busy;
      logic               done;
      logic               was_tare;
      logic [VALUE_W-1:0] value;
   } reading_t;

   // Tracks the reader's conversion state tick by tick and holds the
   // readings it must return, oldest first.
   class reader_scoreboard;
      localparam int DATA_BITS = 24;

      phase_type          phase;
      logic [4:0]         bit_count;
      logic [VALUE_W-1:0] shift_word;
      logic [VALUE_W-1:0] tare_offset;
      logic [VALUE_W-1:0] last_weight;
      logic [VALUE_W-1:0] scale;
      logic               tare_latched;
      logic               clock_level;
      reading_t           expected_readings[$];
      int                 errors;
      int                 result_no;

      function new();
         phase = PH_IDLE;
         bit_count = '0;
         shift_word = '0;
         tare_offset = '0;
         last_weight = '0;
         scale = SCALE_RESET;
         tare_latched = 1'b0;
         clock_level = 1'b1;
         errors = 0;
         result_no = 0;
      endfunction

      function logic [VALUE_W-1:0] weight_of(logic [VALUE_W-1:0] diff);
         logic [63:0] num;
         logic [63:0] quo;
         num = 64'(diff) << FRAC_BITS;
         if (scale == '0) return FULL_SCALE;
         quo = num / 64'(scale);
         if (quo > 64'(FULL_SCALE)) return FULL_SCALE;
         return quo[VALUE_W-1:0];
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function void predict_tick(logic start, logic tare, logic dout);
         reading_t           r;
         logic [VALUE_W-1:0] raw;
         r.busy = 1'b1;
         r.done = 1'b0;
         r.was_tare = 1'b0;
         r.value = '0;
         case (phase)
            PH_IDLE: begin
               r.busy = 1'b0;
               if (start) begin
                  clock_level = 1'b0;
                  tare_latched = tare;
                  phase = PH_WAIT;
                  r.busy = 1'b1;
               end
            end
            PH_WAIT: begin
               clock_level = 1'b0;
               if (!dout) begin
                  bit_count = '0;
                  shift_word = '0;
                  phase = PH_HIGH;
               end
            end
            PH_HIGH: begin
               clock_level = 1'b1;
               shift_word = {shift_word[VALUE_W-2:0], 1'b0};
               phase = PH_LOW;
            end
            PH_LOW: begin
               clock_level = 1'b0;
               shift_word[0] = dout;
               bit_count = bit_count + 5'd1;
               phase = (bit_count >= DATA_BITS) ? PH_XHIGH : PH_HIGH;
            end
            PH_XHIGH: begin
               clock_level = 1'b1;
               phase = PH_XLOW;
            end
            default: begin
               raw = shift_word ^ SIGN_FLIP;
               clock_level = 1'b0;
               r.busy = 1'b0;
               r.done = 1'b1;
               if (tare_latched) begin
                  tare_offset = raw;
                  r.was_tare = 1'b1;
                  r.value = raw;
               end else begin
                  if (raw > tare_offset) last_weight = weight_of(raw - tare_offset);
                  r.value = last_weight;
               end
               phase = PH_IDLE;
            end
         endcase
         r.sck = clock_level;
         expected_readings.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_reading(reading_t got);
         reading_t want;
         result_no++;
         if (expected_readings.size() == 0) begin
            report($sformatf("result word %0d arrived with nothing expected", result_no));
            return;
         end
         want = expected_readings.pop_front();
         if (got.sck !== want.sck)
            report($sformatf("word %0d sck %b, want %b", result_no, got.sck, want.sck));
         if (got.busy !== want.busy)
            report($sformatf("word %0d busy %b, want %b", result_no, got.busy, want.busy));
         if (got.done !== want.done)
            report($sformatf("word %0d done %b, want %b", result_no, got.done, want.done));
         if (got.was_tare !== want.was_tare)
            report($sformatf("word %0d was_tare %b, want %b", result_no, got.was_tare,
                             want.was_tare));
         if (got.value !== want.value)
            report($sformatf("word %0d value %h, want %h", result_no, got.value, want.value));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_start_req = 1'b0;
   logic               req_tare = 1'b0;
   logic               req_dout = 1'b1;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_sck;
   logic               rsp_busy_res;
   logic               rsp_done_res;
   logic               rsp_was_tare;
   logic [VALUE_W-1:0] rsp_value;
   logic               csr_wr_en = 1'b0;
   logic [VALUE_W-1:0] csr_wr_data = '0;

   reader_scoreboard sb;
   bit snd_calm = 1'b0;
   bit rcv_calm = 1'b0;
   int rsp_seen = 0;
   int sent_ticks = 0;
   int conv_ticks = 0;
   int conv_no = 0;

   load_cell_adc_reader_with_tare uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_start_req(req_start_req),
      .req_tare(req_tare),
      .req_dout(req_dout),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sck(rsp_sck),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_was_tare(rsp_was_tare),
      .rsp_value(rsp_value),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_wait();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FULL_SCALE;
         2: return sb.tare_offset;
         3: return sb.tare_offset + VALUE_W'($urandom_range(1, 300));
         4: return sb.tare_offset - VALUE_W'($urandom_range(1, 300));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_scale();
      case ($urandom_range(0, 9))
         0: return FULL_SCALE;
         1: return 24'd256;
         2: return VALUE_W'($urandom_range(0, 255));
         3: return SCALE_RESET;
         4, 5: return VALUE_W'($urandom_range(256, 65535));
         default: return VALUE_W'($urandom_range(256, 24'hFFFFFF));
      endcase
   endfunction

   // Offers one tick word after a random gap and returns at the edge that
   // takes it. Signals are steady from the falling edge to the next rising
   // edge, so a ready seen at the falling edge means the word goes in.
   task automatic send_tick(input logic start, input logic tare, input logic dout);
      int gap;
      gap = pick_gap(snd_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_tare <= tare;
      req_dout <= dout;
      do @(negedge clock); while (!req_ready);
      sb.predict_tick(start, tare, dout);
      @(posedge clock);
      sent_ticks++;
      if (sent_ticks % 128 == 0) snd_calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic idle_ticks(input int n);
      repeat (n) send_tick(1'b0, coin(), coin());
   endtask

   // One full conversion: start, some ticks with the data pin still high,
   // then the pin low, the data bits MSB first and the gain pulse. Start
   // and tare are random on every busy tick, since the reader ignores them.
   task automatic convert(input logic tare, input logic [VALUE_W-1:0] raw, input int waits);
      logic [VALUE_W-1:0] pattern;
      pattern = raw ^ SIGN_FLIP;
      send_tick(1'b1, tare, coin());
      repeat (waits) send_tick(coin(), coin(), 1'b1);
      send_tick(coin(), coin(), 1'b0);
      for (int i = VALUE_W - 1; i >= 0; i--) begin
         send_tick(coin(), coin(), coin());
         send_tick(coin(), coin(), pattern[i]);
      end
      send_tick(coin(), coin(), coin());
      send_tick(coin(), coin(), coin());
      conv_ticks += waits + 2 * VALUE_W + 4;
   endtask

   // The weight divider keeps running after its word is taken, so the reader
   // gets some slack before the scale changes.
   task automatic write_scale(input logic [VALUE_W-1:0] v);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.scale = v;
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      reading_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.sck = rsp_sck;
         got.busy = rsp_busy_res;
         got.done = rsp_done_res;
         got.was_tare = rsp_was_tare;
         got.value = rsp_value;
         sb.check_reading(got);
         rsp_seen++;
      end
   end

   // Result side; once, it holds off long enough for the reader to back up.
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && rsp_seen >= 700) begin
            stall = 400;
            held = 1'b1;
         end else begin
            stall = pick_gap(rcv_calm);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(0, 199) == 0) rcv_calm = ~rcv_calm;
      end
   end

   initial begin
      #4_000_000;
      $display("load_cell_adc_reader_with_tare_tb: FAIL");
      $finish;
   end

   initial begin
      sb = new();
      while (reset) @(posedge clock);

      // Clock stays high after reset until the first start.
      idle_ticks(3);
      convert(1'b1, '0, 0);
      convert(1'b0, FULL_SCALE, 1);
      // Raw equal to and below the offset keep the previous weight.
      convert(1'b0, '0, 0);
      convert(1'b1, FULL_SCALE, 60);
      convert(1'b0, SIGN_FLIP, 2);

      write_scale(24'd256);
      convert(1'b1, '0, 0);
      convert(1'b0, FULL_SCALE, 0);
      write_scale('0);
      convert(1'b0, SIGN_FLIP, 0);
      write_scale(24'd1);
      convert(1'b0, 24'd1, 0);
      convert(1'b0, 24'h7FFFFF, 0);
      write_scale(FULL_SCALE);
      convert(1'b0, FULL_SCALE, 1);

      while (conv_ticks < 1900) begin
         if (conv_no % 8 == 7) write_scale(pick_scale());
         idle_ticks($urandom_range(0, 3));
         convert($urandom_range(0, 3) == 0, pick_raw(), pick_wait());
         conv_no++;
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("load_cell_adc_reader_with_tare_tb: PASS");
      else
         $display("load_cell_adc_reader_with_tare_tb: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
design/lcar_pkg.sv
design/lcar_div.sv
design/load_cell_adc_reader_with_tare.sv
design/lcar_checker.sv
tb/sv/load_cell_adc_reader_with_tare_tb.sv
